/* design/vpp_pkg.sv */
// Shared types, constants and helpers for the vertex perspective projection core.
// No dependencies; imported by every module of the block.
package vpp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 32 + FRAC_BITS;   // magnitude of a numerator after scaling
    localparam int ADDR_W    = 5;

    typedef enum logic [2:0] {
        REG_CAMERA_X     = 3'd0,
        REG_CAMERA_Y     = 3'd1,
        REG_CAMERA_Z     = 3'd2,
        REG_X_SCALE      = 3'd3,
        REG_Y_SCALE      = 3'd4,
        REG_DEPTH_SCALE  = 3'd5,
        REG_DEPTH_OFFSET = 3'd6,
        REG_NONE         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] cam_x;
        logic [31:0] cam_y;
        logic [31:0] cam_z;
        logic [31:0] x_scale;
        logic [31:0] y_scale;
        logic [31:0] depth_scale;
        logic [31:0] depth_offset;
    } t_cfg;

    // one division lane: partial remainder, and numerator bits shifting out
    // while quotient bits shift in
    typedef struct packed {
        logic [31:0]      rem;
        logic [NUM_W-1:0] nq;
    } t_lane;

    typedef struct packed {
        logic            vld;
        t_lane [2:0]     lane;
        logic [31:0]     den;
        logic [2:0]      neg;     // quotient sign
        logic [2:0]      num_neg; // numerator sign, for the zero-W case
        logic [2:0]      num_zero;
        logic [31:0]     w;
        logic            dz;
        logic            ov;
    } t_cell;

    localparam logic signed [63:0] MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] MIN64 = -64'sd2147483648;

    // {saturated flag, value}
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > MAX64) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < MIN64) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sx64(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

/* design/vertex_perspective_project_core.sv */
// Top level of the vertex perspective projection core.
// Depends on vpp_pkg, vpp_clip and vpp_div_cell.
//
// Usage:
//  - Slave stream: one vertex per transaction, i_s_tdata = {pos_z, pos_y, pos_x}.
//  - Master stream: one result per vertex, o_m_tdata = {clip_w, ndc_z, ndc_y, ndc_x},
//    o_m_tuser = {overflow, div_zero}.
//  - APB port writes/reads the seven projection registers at byte address 4*index.
//    Registers are only to be written while no vertex is in flight.
//  - Pipeline: 3 front-end stages, NUM_W (48) division cells, 1 output register.
//  - Throughput: one vertex per cycle unless stalled; the division is a row of cells,
//    each resolving one quotient bit of all three lanes, so items overlap fully.
//  - Stall: the whole row advances together; when the output holds a result the
//    sink has not taken, the row freezes and o_s_tready drops. Bubbles in the
//    row do not free it.
//  - Reset (synchronous, active low): clears all valid bits and loads the
//    register defaults (scales 1.0, depth scale -1.0, everything else 0).
module vertex_perspective_project_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [95:0]                i_s_tdata,   // pos_x, pos_y, pos_z
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [127:0]               o_m_tdata,   // ndc_x, ndc_y, ndc_z, clip_w
    output logic [1:0]                 o_m_tuser,   // div_zero, overflow
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vpp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import vpp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     en;

    t_cell chain [NUM_W+1];

    logic         r_out_vld;
    logic [127:0] r_out_data, n_out_data;
    logic [1:0]   r_out_user, n_out_user;

    // ---------------- register file ----------------
    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x        <= '0;
            r_cfg.cam_y        <= '0;
            r_cfg.cam_z        <= '0;
            r_cfg.x_scale      <= 32'h0001_0000;
            r_cfg.y_scale      <= 32'h0001_0000;
            r_cfg.depth_scale  <= 32'hffff_0000;
            r_cfg.depth_offset <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_CAMERA_X:     r_cfg.cam_x        <= pwdata;
                REG_CAMERA_Y:     r_cfg.cam_y        <= pwdata;
                REG_CAMERA_Z:     r_cfg.cam_z        <= pwdata;
                REG_X_SCALE:      r_cfg.x_scale      <= pwdata;
                REG_Y_SCALE:      r_cfg.y_scale      <= pwdata;
                REG_DEPTH_SCALE:  r_cfg.depth_scale  <= pwdata;
                REG_DEPTH_OFFSET: r_cfg.depth_offset <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CAMERA_X:     prdata = r_cfg.cam_x;
            REG_CAMERA_Y:     prdata = r_cfg.cam_y;
            REG_CAMERA_Z:     prdata = r_cfg.cam_z;
            REG_X_SCALE:      prdata = r_cfg.x_scale;
            REG_Y_SCALE:      prdata = r_cfg.y_scale;
            REG_DEPTH_SCALE:  prdata = r_cfg.depth_scale;
            REG_DEPTH_OFFSET: prdata = r_cfg.depth_offset;
            default:          prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    // global advance: output slot empty or being taken this cycle
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    vpp_clip u_clip (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_s_tvalid),
        .i_data (i_s_tdata),
        .i_cfg  (r_cfg),
        .o_cell (chain[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        vpp_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    // sign fix-up, saturation and zero-W override
    always_comb begin
        logic [NUM_W-1:0] q;
        logic [31:0]      v;
        logic             ov;
        q  = '0;
        v  = '0;
        ov = chain[NUM_W].ov;
        n_out_data = '0;
        for (int i = 0; i < 3; i++) begin
            q = chain[NUM_W].lane[i].nq;
            if (chain[NUM_W].dz) begin
                if (chain[NUM_W].num_zero[i]) begin
                    v = '0;
                end else if (chain[NUM_W].num_neg[i]) begin
                    v = 32'h8000_0000;
                end else begin
                    v = 32'h7fff_ffff;
                end
            end else if (chain[NUM_W].neg[i]) begin
                if (q > NUM_W'(33'h0_8000_0000)) begin
                    v  = 32'h8000_0000;
                    ov = 1'b1;
                end else begin
                    v = 32'd0 - q[31:0];
                end
            end else begin
                if (q > NUM_W'(32'h7fff_ffff)) begin
                    v  = 32'h7fff_ffff;
                    ov = 1'b1;
                end else begin
                    v = q[31:0];
                end
            end
            n_out_data[32*i +: 32] = v;
        end
        n_out_data[127:96] = chain[NUM_W].dz ? '0 : chain[NUM_W].w;
        n_out_user = {ov, chain[NUM_W].dz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= chain[NUM_W].vld;
        end
        if (en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

/* design/vpp_clip.sv */
// Front end: camera-space subtract, clip products, shift and saturate, divider set-up.
// Depends on vpp_pkg.
module vpp_clip (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [95:0]    i_data,
    input  vpp_pkg::t_cfg  i_cfg,
    output vpp_pkg::t_cell o_cell
);
    import vpp_pkg::*;

    // stage 1
    logic        r_v1, r_ov1;
    logic [31:0] r_xc, r_yc, r_zc;
    // stage 2
    logic               r_v2, r_ov2;
    logic signed [63:0] r_px, r_py, r_pz;
    logic [31:0]        r_w;
    // stage 3
    t_cell r_cell, n_cell;

    logic [32:0] s_x, s_y, s_z, s_w;
    logic [32:0] s_cx, s_cy, s_cz;
    logic [31:0] c [3];
    logic [31:0] mag;
    logic        wneg;

    assign s_x = sat32(sx64(i_data[31:0])  - sx64(i_cfg.cam_x));
    assign s_y = sat32(sx64(i_data[63:32]) - sx64(i_cfg.cam_y));
    assign s_z = sat32(sx64(i_data[95:64]) - sx64(i_cfg.cam_z));
    assign s_w = sat32(-sx64(r_zc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_xc  <= s_x[31:0];
            r_yc  <= s_y[31:0];
            r_zc  <= s_z[31:0];
            r_ov1 <= s_x[32] | s_y[32] | s_z[32];
            r_px  <= $signed(i_cfg.x_scale) * $signed(r_xc);
            r_py  <= $signed(i_cfg.y_scale) * $signed(r_yc);
            r_pz  <= $signed(i_cfg.depth_scale) * $signed(r_zc);
            r_w   <= s_w[31:0];
            r_ov2 <= r_ov1 | s_w[32];
        end
    end

    // arithmetic shift floors, as required
    assign s_cx = sat32(r_px >>> FRAC_BITS);
    assign s_cy = sat32(r_py >>> FRAC_BITS);
    assign s_cz = sat32((r_pz >>> FRAC_BITS) + sx64(i_cfg.depth_offset));

    always_comb begin
        mag    = '0;
        c[0]   = s_cx[31:0];
        c[1]   = s_cy[31:0];
        c[2]   = s_cz[31:0];
        wneg   = r_w[31];
        n_cell = '0;
        n_cell.vld = r_v2;
        n_cell.w   = r_w;
        n_cell.dz  = (r_w == '0);
        n_cell.den = wneg ? (32'd0 - r_w) : r_w;
        n_cell.ov  = r_ov2 | s_cx[32] | s_cy[32] | s_cz[32];
        for (int i = 0; i < 3; i++) begin
            mag = c[i][31] ? (32'd0 - c[i]) : c[i];
            n_cell.lane[i].rem = '0;
            n_cell.lane[i].nq  = NUM_W'(mag) << FRAC_BITS;
            n_cell.neg[i]      = c[i][31] ^ wneg;
            n_cell.num_neg[i]  = c[i][31];
            n_cell.num_zero[i] = (c[i] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.lane     <= n_cell.lane;
            r_cell.den      <= n_cell.den;
            r_cell.neg      <= n_cell.neg;
            r_cell.num_neg  <= n_cell.num_neg;
            r_cell.num_zero <= n_cell.num_zero;
            r_cell.w        <= n_cell.w;
            r_cell.dz       <= n_cell.dz;
            r_cell.ov       <= n_cell.ov;
        end
    end

    assign o_cell = r_cell;

endmodule

/* design/vpp_div_cell.sv */
// One restoring-division cell: resolves one quotient bit on all three lanes.
// Depends on vpp_pkg.
module vpp_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  vpp_pkg::t_cell i_cell,
    output vpp_pkg::t_cell o_cell
);
    import vpp_pkg::*;

    t_cell       r_cell, n_cell;
    logic [32:0] t;
    logic [32:0] d;

    always_comb begin
        n_cell = i_cell;
        d      = {1'b0, i_cell.den};
        t      = '0;
        for (int i = 0; i < 3; i++) begin
            t = {i_cell.lane[i].rem, i_cell.lane[i].nq[NUM_W-1]};
            if (t >= d) begin
                t = t - d;
                n_cell.lane[i].nq = {i_cell.lane[i].nq[NUM_W-2:0], 1'b1};
            end else begin
                n_cell.lane[i].nq = {i_cell.lane[i].nq[NUM_W-2:0], 1'b0};
            end
            n_cell.lane[i].rem = t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.lane     <= n_cell.lane;
            r_cell.den      <= n_cell.den;
            r_cell.neg      <= n_cell.neg;
            r_cell.num_neg  <= n_cell.num_neg;
            r_cell.num_zero <= n_cell.num_zero;
            r_cell.w        <= n_cell.w;
            r_cell.dz       <= n_cell.dz;
            r_cell.ov       <= n_cell.ov;
        end
    end

    assign o_cell = r_cell;

endmodule
